>>> hdl/sha1_hash_unit_defines.svh
// ----------------------------------------------------------------------------
// sha1_hash_unit_defines
// assertion macros shared by the hash unit modules
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_UNIT_DEFINES_SVH
`define SHA1_HASH_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// types, constants and helpers shared by the hash unit controller and datapath
// ----------------------------------------------------------------------------
package sha1_pkg;

    // initial chain value h0..h4
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [4:0][31:0] H_INIT = {H4, H3, H2, H1, H0};

    // round constants
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         COUNT_W    = 61;
    localparam int         ROUND_W    = 7;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_Q1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_Q2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_Q3   = 7'd60;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_FINISH
    } sha1_state_t;

    // source of the byte pushed into the block
    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } sha1_sel_t;

    // round function group
    typedef enum logic [1:0] {
        RF_CHOOSE,
        RF_PARITY_A,
        RF_MAJORITY,
        RF_PARITY_B
    } sha1_rfn_t;

    // controller to datapath commands
    typedef struct packed {
        logic      push;
        sha1_sel_t byte_sel;
        logic      word_done;
        logic [2:0] len_idx;
        logic      count_inc;
        logic      load_work;
        logic      round;
        sha1_rfn_t rfn;
        logic      add_chain;
        logic      finish;
    } sha1_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } sha1_status_t;

    // one byte of the 64-bit big-endian bit count
    function automatic logic [7:0] length_byte(input logic [COUNT_W-1:0] cnt,
                                               input logic [2:0] idx);
        logic [63:0] bits;
        logic [7:0]  res;
        bits = {cnt, 3'b000};
        case (idx)
            3'd0:    res = bits[63:56];
            3'd1:    res = bits[55:48];
            3'd2:    res = bits[47:40];
            3'd3:    res = bits[39:32];
            3'd4:    res = bits[31:24];
            3'd5:    res = bits[23:16];
            3'd6:    res = bits[15:8];
            default: res = bits[7:0];
        endcase
        return res;
    endfunction

endpackage

>>> hdl/sha1_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer for byte intake, padding, the 80-round loop and digest hand-off
// ----------------------------------------------------------------------------
`include "sha1_hash_unit_defines.svh"

module sha1_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic                  s_axis_tuser,   // [0] byte_valid
    input  logic                  s_axis_tlast,   // last_item
    output sha1_pkg::sha1_cmd_t   cmd,
    input  sha1_pkg::sha1_status_t status
);
    import sha1_pkg::*;

    sha1_state_t        state_reg, state_next;
    logic [5:0]         fill_reg, fill_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               pad_reg, pad_next;
    logic               first_reg, first_next;
    logic               len_reg, len_next;
    logic               pend_reg, pend_next;
    logic               acc;
    logic               fill_full;
    logic               len_zone;

    assign acc       = s_axis_tvalid && s_axis_tready;
    assign fill_full = (fill_reg == FILL_LAST);
    assign len_zone  = (fill_reg >= LEN_START);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (s_axis_tuser && fill_full)
                        state_next = ST_LOAD;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_full)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                    state_next = (pad_reg && len_reg) ? ST_FINISH : ST_ADD;
            end
            ST_ADD:
            begin
                if (pad_reg || pend_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = SEL_MSG;
        cmd.rfn       = RF_CHOOSE;
        cmd.word_done = (fill_reg[1:0] == 2'b11);
        cmd.len_idx   = fill_reg[2:0];
        case (state_reg)
            ST_IDLE:
            begin
                // ready is always high here, so valid alone marks the accept
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser)
                begin
                    cmd.push      = 1'b1;
                    cmd.count_inc = 1'b1;
                end
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                if (first_reg)
                    cmd.byte_sel = SEL_PAD;
                else if (len_reg && len_zone)
                    cmd.byte_sel = SEL_LEN;
                else
                    cmd.byte_sel = SEL_ZERO;
            end
            ST_LOAD:
                cmd.load_work = 1'b1;
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (round_reg < ROUND_Q1)
                    cmd.rfn = RF_CHOOSE;
                else if (round_reg < ROUND_Q2)
                    cmd.rfn = RF_PARITY_A;
                else if (round_reg < ROUND_Q3)
                    cmd.rfn = RF_MAJORITY;
                else
                    cmd.rfn = RF_PARITY_B;
            end
            ST_ADD:
                cmd.add_chain = 1'b1;
            ST_FINISH:
                cmd.finish = status.out_free;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // fill, round and padding flags
    always_comb
    begin
        fill_next  = fill_reg;
        round_next = round_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        if (cmd.push)
            fill_next = fill_reg + 6'd1;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (s_axis_tuser && fill_full)
                        pend_next = s_axis_tlast;
                    else if (s_axis_tlast)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    len_next   = (fill_reg < LEN_START);
                end
            end
            ST_LOAD:
                round_next = '0;
            ST_ROUND:
                round_next = round_reg + 7'd1;
            ST_ADD:
            begin
                if (pad_reg)
                    len_next = 1'b1;
                else if (pend_reg)
                begin
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                    pend_next  = 1'b0;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    pad_next = 1'b0;
                    len_next = 1'b0;
                end
            end
            default:
            begin
                pad_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            len_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            round_reg <= round_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    // a byte that completes a block starts a compression
    `SHA1_ASSERT_NEXT(a_full_block_loads, acc && s_axis_tuser && fill_full,
        state_reg == ST_LOAD, "full block did not start compression")
    // round counter stays inside the 80-round loop
    `SHA1_ASSERT_NOW(a_round_range, state_reg == ST_ROUND, round_reg <= ROUND_LAST,
        "round counter out of range")
    // digest is only written into a free output slot
    `SHA1_ASSERT_NOW(a_finish_free, cmd.finish, status.out_free && pad_reg && len_reg,
        "digest written while output slot busy")

endmodule

>>> hdl/sha1_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_datapath
// message window, working variables, chain value, length count and output slot
// ----------------------------------------------------------------------------
`include "sha1_hash_unit_defines.svh"

module sha1_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  sha1_pkg::sha1_cmd_t    cmd,
    output sha1_pkg::sha1_status_t status,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [159:0]           m_axis_tdata
);
    import sha1_pkg::*;

    logic [31:0]         win_reg [16];
    logic [23:0]         acc_reg;
    logic [4:0][31:0]    work_reg;
    logic [4:0][31:0]    chain_reg, chain_next;
    logic [4:0][31:0]    out_reg;
    logic [4:0][31:0]    sum;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                valid_reg, valid_next;
    logic [7:0]          push_byte;
    logic [31:0]         sched_mix;
    logic [31:0]         fval;
    logic [31:0]         kval;
    logic [31:0]         tval;
    logic [31:0]         wa, wb, wc, wd, we;

    assign wa = work_reg[0];
    assign wb = work_reg[1];
    assign wc = work_reg[2];
    assign wd = work_reg[3];
    assign we = work_reg[4];

    // byte source select
    always_comb
    begin
        case (cmd.byte_sel)
            SEL_MSG:  push_byte = data_byte;
            SEL_PAD:  push_byte = PAD_BYTE;
            SEL_LEN:  push_byte = length_byte(count_reg, cmd.len_idx);
            default:  push_byte = 8'h00;
        endcase
    end

    // round function and constant
    always_comb
    begin
        case (cmd.rfn)
            RF_CHOOSE:
            begin
                fval = (wb & wc) | (~wb & wd);
                kval = K0;
            end
            RF_PARITY_A:
            begin
                fval = wb ^ wc ^ wd;
                kval = K1;
            end
            RF_MAJORITY:
            begin
                fval = (wb & wc) | (wb & wd) | (wc & wd);
                kval = K2;
            end
            default:
            begin
                fval = wb ^ wc ^ wd;
                kval = K3;
            end
        endcase
    end

    assign tval      = {wa[26:0], wa[31:27]} + fval + we + kval + win_reg[0];
    assign sched_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];

    // chain plus working variables
    always_comb
    begin
        for (int i = 0; i < 5; i++)
            sum[i] = chain_reg[i] + work_reg[i];
    end

    // message window: words shift in during intake, schedule rolls during rounds
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            if (cmd.word_done)
            begin
                for (int i = 0; i < 15; i++)
                    win_reg[i] <= win_reg[i + 1];
                win_reg[15] <= {acc_reg, push_byte};
            end
            else
                acc_reg <= {acc_reg[15:0], push_byte};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= {sched_mix[30:0], sched_mix[31]};
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
            work_reg <= chain_reg;
        else if (cmd.round)
        begin
            work_reg[0] <= tval;
            work_reg[1] <= wa;
            work_reg[2] <= {wb[1:0], wb[31:2]};
            work_reg[3] <= wc;
            work_reg[4] <= wd;
        end
    end

    // digest word slot
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_reg <= sum;
    end

    // chain, length count and output valid next values
    always_comb
    begin
        chain_next = chain_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (m_axis_tready)
            valid_next = 1'b0;
        if (cmd.count_inc)
            count_next = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
        if (cmd.add_chain)
            chain_next = sum;
        if (cmd.finish)
        begin
            chain_next = H_INIT;
            count_next = '0;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= H_INIT;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    assign status.out_free = !valid_reg || m_axis_tready;
    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = out_reg;

    // a finished digest is presented in the next cycle
    `SHA1_ASSERT_NEXT(a_finish_valid, cmd.finish, m_axis_tvalid,
        "digest not presented after finish")
    // the chain and count restart for the next message
    `SHA1_ASSERT_NEXT(a_finish_reinit, cmd.finish,
        chain_reg == H_INIT && count_reg == '0, "chain not reinitialized")
    // only message bytes advance the length count
    `SHA1_ASSERT_NOW(a_count_msg, cmd.count_inc,
        cmd.push && cmd.byte_sel == SEL_MSG, "length count on non-message byte")

endmodule

>>> hdl/sha1_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_unit
// streaming SHA-1 engine: message bytes in, 160-bit digest out
// ----------------------------------------------------------------------------
// usage
//   input word: s_axis_tdata = message byte, s_axis_tuser = byte valid,
//   s_axis_tlast = end of message; tuser low with tlast high ends the
//   message without adding a byte, tuser and tlast both low is a no-op
//   output word: one 160-bit digest per message, h0 in the lowest bits
//   throughput: one byte per cycle while a block fills; every 64th byte
//   holds the input off for the compression (load, 80 rounds at one round
//   per cycle in the shared round unit, chain add)
//   end of message: after the last word, padding pushes one byte per cycle
//   up to the block end, then one or two compressions follow (load, 80
//   rounds, chain add or finish); the digest shows on m_axis the cycle
//   after the finish step
//   reset: chain returns to the initial value, counts clear, no output
//   stall: the digest waits in its output register; intake of the next
//   message goes on, and only the next digest waits for the slot to free
// ----------------------------------------------------------------------------

module sha1_hash_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] byte_valid
    input  logic         s_axis_tlast,   // last_item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // [31:0] digest_word0 .. [159:128] digest_word4
);
    import sha1_pkg::*;

    sha1_cmd_t    cmd;
    sha1_status_t status;

    // sequencer
    sha1_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

    // hash datapath
    sha1_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
